/* rtl/core/encoder_motion_start_detector_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the encoder motion start detector
// Short forms for clocked, reset-qualified implications.
// ----------------------------------------------------------------------------
`ifndef ENCODER_MOTION_START_DETECTOR_MACROS_SVH
`define ENCODER_MOTION_START_DETECTOR_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define EMSD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset.
`define EMSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/emsd_pkg.sv */
// ----------------------------------------------------------------------------
// Encoder motion start detector package
// Shared types, register indexes, reset values and phase encoding.
// ----------------------------------------------------------------------------
package emsd_pkg;

   // Request operation codes
   typedef enum logic [1:0] {
      OP_EDGE  = 2'd0,
      OP_TICK  = 2'd1,
      OP_START = 2'd2
   } op_type;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_WINDOW_TICKS   = 2'd0,
      CSR_LOW_THRESHOLD  = 2'd1,
      CSR_HIGH_THRESHOLD = 2'd2
   } csr_idx_type;

   localparam logic        [15:0] WINDOW_TICKS_RST   = 16'd50;
   localparam logic signed [15:0] LOW_THRESHOLD_RST  = 16'sd20;
   localparam logic signed [15:0] HIGH_THRESHOLD_RST = 16'sd50;

   localparam logic signed [15:0] WIN_MAX = 16'sh7FFF;
   localparam logic signed [15:0] WIN_MIN = 16'sh8000;
   localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] POS_MIN = 32'sh8000_0000;
   localparam logic        [15:0] TICKS_MAX = 16'hFFFF;

   localparam logic [2:0] PHASE_LAST = 3'd5;

   // Start sequence phases, one-hot
   typedef enum logic [5:0] {
      PH_SLOW0 = 6'b000001,
      PH_DIP0  = 6'b000010,
      PH_RISE0 = 6'b000100,
      PH_DIP1  = 6'b001000,
      PH_RISE1 = 6'b010000,
      PH_SLOW1 = 6'b100000
   } phase_type;

   // Velocity latch event from the counters to the sequencer
   typedef struct packed {
      logic               latch;
      logic signed [15:0] velocity;
   } latch_type;

   function automatic logic [2:0] phase_code(input phase_type ph);
      logic [2:0] code;
      case (ph)
         PH_SLOW0: code = 3'd0;
         PH_DIP0:  code = 3'd1;
         PH_RISE0: code = 3'd2;
         PH_DIP1:  code = 3'd3;
         PH_RISE1: code = 3'd4;
         default:  code = PHASE_LAST;
      endcase
      return code;
   endfunction

endpackage

/* rtl/core/emsd_counter.sv */
// ----------------------------------------------------------------------------
// Encoder counters
// Position and window counters, window timer and velocity latch.
// ----------------------------------------------------------------------------
module emsd_counter (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  emsd_pkg::op_type          op,
   input  logic                      p2_level,
   input  logic               [15:0] window_ticks,
   input  logic                      clear_pos,
   output emsd_pkg::latch_type       latch_ev,
   output logic signed        [31:0] position_in,
   output logic signed        [15:0] velocity_in
);

   logic signed [31:0] position_ff, position_nx;
   logic signed [15:0] window_ff, window_in;
   logic        [15:0] elapsed_ff, elapsed_in, elapsed_inc;
   logic signed [15:0] velocity_ff;

   assign elapsed_inc = (elapsed_ff != emsd_pkg::TICKS_MAX) ? elapsed_ff + 16'd1 : elapsed_ff;

   always_comb begin
      position_nx = position_ff;
      window_in   = window_ff;
      elapsed_in  = elapsed_ff;
      velocity_in = velocity_ff;
      latch_ev    = '0;
      case (op)
         emsd_pkg::OP_EDGE: begin
            if (p2_level) begin
               if (window_ff != emsd_pkg::WIN_MAX) window_in = window_ff + 16'sd1;
               if (position_ff != emsd_pkg::POS_MAX) position_nx = position_ff + 32'sd1;
            end else begin
               if (window_ff != emsd_pkg::WIN_MIN) window_in = window_ff - 16'sd1;
               if (position_ff != emsd_pkg::POS_MIN) position_nx = position_ff - 32'sd1;
            end
         end
         emsd_pkg::OP_TICK: begin
            elapsed_in = elapsed_inc;
            if (elapsed_inc > window_ticks) begin
               elapsed_in        = '0;
               velocity_in       = window_ff;
               window_in         = '0;
               latch_ev.latch    = 1'b1;
               latch_ev.velocity = window_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // completed start sequence zeroes the position
   assign position_in = clear_pos ? '0 : position_nx;

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         window_ff   <= '0;
         elapsed_ff  <= '0;
         velocity_ff <= '0;
      end else if (step) begin
         position_ff <= position_in;
         window_ff   <= window_in;
         elapsed_ff  <= elapsed_in;
         velocity_ff <= velocity_in;
      end
   end

endmodule

/* rtl/core/emsd_sequencer.sv */
// ----------------------------------------------------------------------------
// Start sequencer
// Six-phase velocity sequence that completes a pending start.
// ----------------------------------------------------------------------------
module emsd_sequencer (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  emsd_pkg::op_type          op,
   input  emsd_pkg::latch_type       latch_ev,
   input  logic signed        [15:0] low_threshold,
   input  logic signed        [15:0] high_threshold,
   output logic               [2:0]  phase_in,
   output logic                      pending_in,
   output logic                      done,
   output logic                      clear_pos
);

   emsd_pkg::phase_type phase_ff, phase_nx;
   logic                pending_ff;
   logic                below_low, below_high, above_high;

   assign below_low  = latch_ev.velocity < low_threshold;
   assign below_high = latch_ev.velocity < high_threshold;
   assign above_high = latch_ev.velocity > high_threshold;

   always_comb begin
      phase_nx   = phase_ff;
      pending_in = pending_ff;
      done       = 1'b0;
      if (op == emsd_pkg::OP_START) begin
         pending_in = 1'b1;
      end else if (op == emsd_pkg::OP_TICK && latch_ev.latch && pending_ff) begin
         case (phase_ff)
            emsd_pkg::PH_SLOW0: if (below_low)  phase_nx = emsd_pkg::PH_DIP0;
            emsd_pkg::PH_DIP0:  if (below_high) phase_nx = emsd_pkg::PH_RISE0;
            emsd_pkg::PH_RISE0: if (above_high) phase_nx = emsd_pkg::PH_DIP1;
            emsd_pkg::PH_DIP1:  if (below_high) phase_nx = emsd_pkg::PH_RISE1;
            emsd_pkg::PH_RISE1: if (above_high) phase_nx = emsd_pkg::PH_SLOW1;
            default: begin
               phase_nx = emsd_pkg::PH_SLOW1;
               if (below_low) begin
                  pending_in = 1'b0;
                  done       = 1'b1;
               end
            end
         endcase
      end
      phase_in  = emsd_pkg::phase_code(phase_nx);
      clear_pos = done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= emsd_pkg::PH_SLOW0;
         pending_ff <= 1'b0;
      end else if (step) begin
         phase_ff   <= phase_nx;
         pending_ff <= pending_in;
      end
   end

endmodule

/* rtl/core/encoder_motion_start_detector.sv */
// ----------------------------------------------------------------------------
// Encoder motion start detector
// Counts quadrature encoder steps, latches windowed velocity and tracks a
// six-phase start sequence.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel (req_valid/req_stall, req_op, req_p2_level): one request
//    per encoder P1 rising edge, millisecond tick or start request.
//  - Response channel (rsp_valid/rsp_stall): exactly one response per
//    request, in order, carrying the state after that request.
//  - CSR channel (csr_valid/csr_ready, csr_index, csr_data): always ready;
//    write only while no request is in flight.
//  - Path: an accepted request is held in the input register, then its
//    response is registered in the result register and shown as valid.
//    Throughput: one request per cycle while rsp_stall does not hold a
//    waiting response, as the counters and the sequencer update at once.
//  - Stall: while rsp_stall holds a waiting response, one more request is
//    taken into the input register, then req_stall rises until the
//    response drains.
//  - Reset: counters, velocity, phase and pending flag clear; CSRs return
//    to window 50, low threshold 20, high threshold 50.
// ----------------------------------------------------------------------------
`include "encoder_motion_start_detector_macros.svh"

module encoder_motion_start_detector (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic        [1:0]  req_op,
   input  logic               req_p2_level,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_position,
   output logic signed [15:0] rsp_velocity,
   output logic        [2:0]  rsp_phase,
   output logic               rsp_start_pending,
   output logic               rsp_start_done,
   // configuration channel
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic        [1:0]  csr_index,
   input  logic        [15:0] csr_data
);

   // CSRs
   logic        [15:0] window_ticks_ff;
   logic signed [15:0] low_threshold_ff;
   logic signed [15:0] high_threshold_ff;

   // input register
   logic                s1_valid_ff, s1_valid_in;
   emsd_pkg::op_type    s1_op_ff;
   logic                s1_p2_ff;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]  rsp_position_ff;
   logic signed [15:0]  rsp_velocity_ff;
   logic        [2:0]   rsp_phase_ff;
   logic                rsp_pending_ff;
   logic                rsp_done_ff;

   logic                advance;
   logic                step;
   emsd_pkg::latch_type latch_ev;
   logic                clear_pos;
   logic signed [31:0]  position_in;
   logic signed [15:0]  velocity_in;
   logic        [2:0]   phase_in;
   logic                pending_in;
   logic                done;

   // ---------------- configuration ----------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ticks_ff   <= emsd_pkg::WINDOW_TICKS_RST;
         low_threshold_ff  <= emsd_pkg::LOW_THRESHOLD_RST;
         high_threshold_ff <= emsd_pkg::HIGH_THRESHOLD_RST;
      end else if (csr_valid && csr_ready) begin
         case (emsd_pkg::csr_idx_type'(csr_index))
            emsd_pkg::CSR_WINDOW_TICKS:   window_ticks_ff   <= csr_data;
            emsd_pkg::CSR_LOW_THRESHOLD:  low_threshold_ff  <= csr_data;
            emsd_pkg::CSR_HIGH_THRESHOLD: high_threshold_ff <= csr_data;
            default: begin
               // drop writes to unmapped indexes
            end
         endcase
      end
   end

   // ---------------- pipeline control ----------------
   // Advance whenever the result register is empty or being taken.
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign step      = s1_valid_ff && advance;
   assign req_stall = s1_valid_ff && !advance;

   // Hold the input register while stalled, otherwise load the next request.
   assign s1_valid_in = req_stall ? s1_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_op_ff <= emsd_pkg::op_type'(req_op);
         s1_p2_ff <= req_p2_level;
      end
   end

   // ---------------- datapath ----------------
   emsd_counter u_counter (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .op           (s1_op_ff),
      .p2_level     (s1_p2_ff),
      .window_ticks (window_ticks_ff),
      .clear_pos    (clear_pos),
      .latch_ev     (latch_ev),
      .position_in  (position_in),
      .velocity_in  (velocity_in)
   );

   emsd_sequencer u_sequencer (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .op             (s1_op_ff),
      .latch_ev       (latch_ev),
      .low_threshold  (low_threshold_ff),
      .high_threshold (high_threshold_ff),
      .phase_in       (phase_in),
      .pending_in     (pending_in),
      .done           (done),
      .clear_pos      (clear_pos)
   );

   // ---------------- result register ----------------
   assign rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_position_ff <= position_in;
         rsp_velocity_ff <= velocity_in;
         rsp_phase_ff    <= phase_in;
         rsp_pending_ff  <= pending_in;
         rsp_done_ff     <= done;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_position      = rsp_position_ff;
   assign rsp_velocity      = rsp_velocity_ff;
   assign rsp_phase         = rsp_phase_ff;
   assign rsp_start_pending = rsp_pending_ff;
   assign rsp_start_done    = rsp_done_ff;

   // ---------------- assertions ----------------
   `EMSD_ASSERT_IMP(a_done_ends_seq, clock, reset, rsp_valid && rsp_start_done, !rsp_start_pending && rsp_phase == emsd_pkg::PHASE_LAST && rsp_position == 32'sd0, "start done without final phase, cleared pending and zero position")
   `EMSD_ASSERT_IMP(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall, "request stalled while result register can drain")
   `EMSD_ASSERT_NEXT(a_phase_on_tick, clock, reset, step && s1_op_ff != emsd_pkg::OP_TICK, rsp_phase == $past(phase_in), "phase moved on a non-tick request")

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// Encoder motion start detector testbench
// Drives encoder edges, millisecond ticks and start requests through the
// request channel. A request-level predictor of the counters, the velocity
// latch and the six-phase start sequence checks each response that is not
// typed in by hand. A directed walk through the sequence comes first. Random
// windows aimed at the velocity thresholds follow, under several register
// settings, the last with no idling on either side.
// ----------------------------------------------------------------------------
module testbench;

   // Unused request code: the block must report its state unchanged
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // Start sequence phase codes as reported on rsp_phase
   localparam logic [2:0] SEQ_SLOW0 = 3'd0;
   localparam logic [2:0] SEQ_DIP0  = 3'd1;
   localparam logic [2:0] SEQ_RISE0 = 3'd2;
   localparam logic [2:0] SEQ_DIP1  = 3'd3;
   localparam logic [2:0] SEQ_RISE1 = 3'd4;
   localparam logic [2:0] SEQ_SLOW1 = emsd_pkg::PHASE_LAST;

   // Hard stop, far beyond the slowest passing run
   localparam int RUN_LIMIT = 200_000;

   // Receiver hold-off: start after this many responses, hold this long
   localparam int HOLD_AFTER  = 150;
   localparam int HOLD_CYCLES = 64;

   localparam int DIRECTED_ROWS = 25;

   // One response as the block reports it
   typedef struct packed {
      logic signed [31:0] position;
      logic signed [15:0] velocity;
      logic        [2:0]  phase;
      logic               pending;
      logic               done;
   } motion_status_type;

   // One directed request; fixed rows carry the response typed in by hand
   typedef struct packed {
      logic        [1:0]  op;
      logic               p2;
      logic               fixed;
      logic signed [31:0] position;
      logic signed [15:0] velocity;
      logic        [2:0]  phase;
      logic               pending;
      logic               done;
   } stim_row_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic        [1:0]  req_op;
   logic               req_p2_level;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [31:0] rsp_position;
   logic signed [15:0] rsp_velocity;
   logic        [2:0]  rsp_phase;
   logic               rsp_start_pending;
   logic               rsp_start_done;
   logic               csr_valid;
   logic               csr_ready;
   logic        [1:0]  csr_index;
   logic        [15:0] csr_data;

   // Predictor copy of the registers
   logic        [15:0] cfg_window;
   logic signed [15:0] cfg_low;
   logic signed [15:0] cfg_high;

   // Predictor copy of the block state
   logic signed [31:0] mdl_position;
   logic signed [15:0] mdl_window_count;
   logic        [15:0] mdl_elapsed;
   logic signed [15:0] mdl_velocity;
   logic        [2:0]  mdl_phase;
   logic               mdl_pending;

   motion_status_type status_due[$];
   int                mismatches = 0;
   int                results_seen = 0;
   int                idle_pct = 9;

   // Directed walk, run with window 1, low threshold 1 and high threshold 0:
   // every latch takes two ticks, and one edge either way makes a dip or
   // a rise.
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      //  op                  p2    fixed position velocity phase   pend  done
      // out of reset: one step forward, one back
      '{emsd_pkg::OP_EDGE,  1'b1, 1'b1, 32'sd1, 16'sd0, SEQ_SLOW0, 1'b0, 1'b0},
      '{emsd_pkg::OP_EDGE,  1'b0, 1'b1, 32'sd0, 16'sd0, SEQ_SLOW0, 1'b0, 1'b0},
      // unused code changes nothing
      '{OP_UNUSED,          1'b1, 1'b1, 32'sd0, 16'sd0, SEQ_SLOW0, 1'b0, 1'b0},
      // latch while no start is pending: velocity only
      '{emsd_pkg::OP_EDGE,  1'b0, 1'b0, 32'sd0, 16'sd0, SEQ_SLOW0, 1'b0, 1'b0},
      '{emsd_pkg::OP_TICK,  1'b0, 1'b0, 32'sd0, 16'sd0, SEQ_SLOW0, 1'b0, 1'b0},
      '{emsd_pkg::OP_TICK,  1'b1, 1'b0, 32'sd0, 16'sd0, SEQ_SLOW0, 1'b0, 1'b0},
      // start request, then a repeated one
      '{emsd_pkg::OP_START, 1'b0, 1'b0, 32'sd0, 16'sd0, SEQ_SLOW0, 1'b0, 1'b0},
      '{emsd_pkg::OP_START, 1'b1, 1'b0, 32'sd0, 16'sd0, SEQ_SLOW0, 1'b0, 1'b0},
      // slow
      '{emsd_pkg::OP_TICK,  1'b0, 1'b0, 32'sd0, 16'sd0, SEQ_SLOW0, 1'b0, 1'b0},
      '{emsd_pkg::OP_TICK,  1'b0, 1'b0, 32'sd0, 16'sd0, SEQ_SLOW0, 1'b0, 1'b0},
      // dip
      '{emsd_pkg::OP_EDGE,  1'b0, 1'b0, 32'sd0, 16'sd0, SEQ_SLOW0, 1'b0, 1'b0},
      '{emsd_pkg::OP_TICK,  1'b0, 1'b0, 32'sd0, 16'sd0, SEQ_SLOW0, 1'b0, 1'b0},
      '{emsd_pkg::OP_TICK,  1'b0, 1'b0, 32'sd0, 16'sd0, SEQ_SLOW0, 1'b0, 1'b0},
      // rise
      '{emsd_pkg::OP_EDGE,  1'b1, 1'b0, 32'sd0, 16'sd0, SEQ_SLOW0, 1'b0, 1'b0},
      '{emsd_pkg::OP_TICK,  1'b0, 1'b0, 32'sd0, 16'sd0, SEQ_SLOW0, 1'b0, 1'b0},
      '{emsd_pkg::OP_TICK,  1'b0, 1'b0, 32'sd0, 16'sd0, SEQ_SLOW0, 1'b0, 1'b0},
      // dip
      '{emsd_pkg::OP_EDGE,  1'b0, 1'b0, 32'sd0, 16'sd0, SEQ_SLOW0, 1'b0, 1'b0},
      '{emsd_pkg::OP_TICK,  1'b0, 1'b0, 32'sd0, 16'sd0, SEQ_SLOW0, 1'b0, 1'b0},
      '{emsd_pkg::OP_TICK,  1'b0, 1'b0, 32'sd0, 16'sd0, SEQ_SLOW0, 1'b0, 1'b0},
      // rise
      '{emsd_pkg::OP_EDGE,  1'b1, 1'b0, 32'sd0, 16'sd0, SEQ_SLOW0, 1'b0, 1'b0},
      '{emsd_pkg::OP_TICK,  1'b0, 1'b0, 32'sd0, 16'sd0, SEQ_SLOW0, 1'b0, 1'b0},
      '{emsd_pkg::OP_TICK,  1'b0, 1'b0, 32'sd0, 16'sd0, SEQ_SLOW0, 1'b0, 1'b0},
      // final slow window completes: position zeroed, done pulse
      '{emsd_pkg::OP_TICK,  1'b0, 1'b0, 32'sd0, 16'sd0, SEQ_SLOW0, 1'b0, 1'b0},
      '{emsd_pkg::OP_TICK,  1'b0, 1'b1, 32'sd0, 16'sd0, SEQ_SLOW1, 1'b0, 1'b1},
      // a later start finds the phase still at the end
      '{emsd_pkg::OP_START, 1'b0, 1'b1, 32'sd0, 16'sd0, SEQ_SLOW1, 1'b1, 1'b0}
   };

   encoder_motion_start_detector i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_p2_level      (req_p2_level),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_position      (rsp_position),
      .rsp_velocity      (rsp_velocity),
      .rsp_phase         (rsp_phase),
      .rsp_start_pending (rsp_start_pending),
      .rsp_start_done    (rsp_start_done),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #1 clock = ~clock;

   // Advance the start sequence on one latched velocity; return the done pulse
   function automatic logic advance_phase(input logic signed [15:0] v);
      logic finished;
      finished = 1'b0;
      case (mdl_phase)
         SEQ_SLOW0: if (v < cfg_low)  mdl_phase = SEQ_DIP0;
         SEQ_DIP0:  if (v < cfg_high) mdl_phase = SEQ_RISE0;
         SEQ_RISE0: if (v > cfg_high) mdl_phase = SEQ_DIP1;
         SEQ_DIP1:  if (v < cfg_high) mdl_phase = SEQ_RISE1;
         SEQ_RISE1: if (v > cfg_high) mdl_phase = SEQ_SLOW1;
         default: begin
            // the phase stays at the end, so a later start finishes early
            mdl_phase = SEQ_SLOW1;
            if (v < cfg_low) begin
               mdl_position = '0;
               mdl_pending  = 1'b0;
               finished     = 1'b1;
            end
         end
      endcase
      return finished;
   endfunction

   // Apply one request to the predictor state and return the response due
   function automatic motion_status_type predict_motion(input logic [1:0] op,
                                                        input logic p2);
      motion_status_type st;
      st.done = 1'b0;
      case (op)
         emsd_pkg::OP_EDGE: begin
            // both counters saturate at their limits
            if (p2) begin
               if (mdl_window_count != emsd_pkg::WIN_MAX) mdl_window_count++;
               if (mdl_position != emsd_pkg::POS_MAX) mdl_position++;
            end else begin
               if (mdl_window_count != emsd_pkg::WIN_MIN) mdl_window_count--;
               if (mdl_position != emsd_pkg::POS_MIN) mdl_position--;
            end
         end
         emsd_pkg::OP_TICK: begin
            if (mdl_elapsed != emsd_pkg::TICKS_MAX) mdl_elapsed++;
            if (mdl_elapsed > cfg_window) begin
               mdl_elapsed      = '0;
               mdl_velocity     = mdl_window_count;
               mdl_window_count = '0;
               if (mdl_pending) st.done = advance_phase(mdl_velocity);
            end
         end
         emsd_pkg::OP_START: mdl_pending = 1'b1;
         default: ;
      endcase
      st.position = mdl_position;
      st.velocity = mdl_velocity;
      st.phase    = mdl_phase;
      st.pending  = mdl_pending;
      return st;
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
   endtask

   // Offer one request after a random gap, hold it until accepted, then
   // queue its response. Fixed rows queue the hand-typed response instead.
   task automatic send_request(input logic [1:0] op, input logic p2,
                               input logic fixed = 1'b0,
                               input motion_status_type typed = '0);
      motion_status_type st;
      while ($urandom_range(0, 99) < idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid    <= 1'b1;
      req_op       <= op;
      req_p2_level <= p2;
      do @(posedge clock); while (req_stall);
      st = predict_motion(op, p2);
      status_due.push_back(fixed ? typed : st);
   endtask

   task automatic write_csr(input emsd_pkg::csr_idx_type idx, input logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         emsd_pkg::CSR_WINDOW_TICKS:  cfg_window = value;
         emsd_pkg::CSR_LOW_THRESHOLD: cfg_low    = value;
         default:                     cfg_high   = value;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Drop valid, wait out every queued response, then let the pipe settle
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (status_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Mostly well-formed velocity windows: edges toward a velocity near one
   // of the thresholds, mixed with just enough ticks to latch it at the end
   // of the window. The rest is noise of any code.
   task automatic random_traffic(input int budget);
      int sent;
      int aim;
      int steps;
      int ticks_left;
      sent = 0;
      while (sent < budget) begin
         if ($urandom_range(0, 99) < 15) begin
            send_request(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
            sent++;
         end else begin
            // arm the sequence, and now and then re-arm it while armed
            if (!mdl_pending || $urandom_range(0, 19) == 0) begin
               send_request(emsd_pkg::OP_START, 1'($urandom_range(0, 1)));
               sent++;
            end
            aim = (($urandom_range(0, 1) != 0) ? int'(cfg_low) : int'(cfg_high))
                  + int'($urandom_range(0, 4)) - 2;
            // keep far thresholds from costing thousands of edges
            if (aim > 60 || aim < -60) aim = int'($urandom_range(0, 120)) - 60;
            steps = aim - int'(mdl_window_count);
            ticks_left = (int'(mdl_elapsed) >= int'(cfg_window)) ? 1 :
                         int'(cfg_window) - int'(mdl_elapsed) + 1;
            while (steps != 0 || ticks_left > 1) begin
               if (steps != 0 && (ticks_left == 1 || $urandom_range(0, 2) != 0)) begin
                  send_request(emsd_pkg::OP_EDGE, steps > 0);
                  steps += (steps > 0) ? -1 : 1;
               end else begin
                  send_request(emsd_pkg::OP_TICK, 1'($urandom_range(0, 1)));
                  ticks_left--;
               end
               sent++;
            end
            // closing tick latches the aimed velocity
            send_request(emsd_pkg::OP_TICK, 1'($urandom_range(0, 1)));
            sent++;
         end
      end
   endtask

   // Settle, load all three registers, then run random windows
   task automatic run_phase(input logic [15:0] window, input logic signed [15:0] low,
                            input logic signed [15:0] high, input int pct,
                            input int budget);
      drain();
      write_csr(emsd_pkg::CSR_WINDOW_TICKS, window);
      write_csr(emsd_pkg::CSR_LOW_THRESHOLD, low);
      write_csr(emsd_pkg::CSR_HIGH_THRESHOLD, high);
      idle_pct = pct;
      random_traffic(budget);
   endtask

   // Check each accepted response against the oldest one due
   always @(posedge clock) begin : response_check
      motion_status_type seen;
      motion_status_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         seen.position = rsp_position;
         seen.velocity = rsp_velocity;
         seen.phase    = rsp_phase;
         seen.pending  = rsp_start_pending;
         seen.done     = rsp_start_done;
         if (status_due.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            want = status_due.pop_front();
            if (seen.position !== want.position)
               report_mismatch($sformatf("position %0d, want %0d",
                                         seen.position, want.position));
            if (seen.velocity !== want.velocity)
               report_mismatch($sformatf("velocity %0d, want %0d",
                                         seen.velocity, want.velocity));
            if (seen.phase !== want.phase)
               report_mismatch($sformatf("phase %0d, want %0d",
                                         seen.phase, want.phase));
            if (seen.pending !== want.pending)
               report_mismatch($sformatf("start_pending %0b, want %0b",
                                         seen.pending, want.pending));
            if (seen.done !== want.done)
               report_mismatch($sformatf("start_done %0b, want %0b",
                                         seen.done, want.done));
         end
      end
   end

   // Response stall: random idling, plus one long hold-off once the run is
   // under way, so the block fills up and stalls the request side
   initial begin : stall_driver
      int  hold_left;
      bit  held;
      hold_left = 0;
      held      = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && results_seen >= HOLD_AFTER) begin
            held      = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < idle_pct);
         end
      end
   end

   initial begin : watchdog
      #(RUN_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   initial begin : stimulus
      int row;
      motion_status_type typed;

      // known values on every input before the first edge
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_op       = emsd_pkg::OP_EDGE;
      req_p2_level = 1'b0;
      csr_valid    = 1'b0;
      csr_index    = emsd_pkg::CSR_WINDOW_TICKS;
      csr_data     = '0;

      cfg_window       = emsd_pkg::WINDOW_TICKS_RST;
      cfg_low          = emsd_pkg::LOW_THRESHOLD_RST;
      cfg_high         = emsd_pkg::HIGH_THRESHOLD_RST;
      mdl_position     = '0;
      mdl_window_count = '0;
      mdl_elapsed      = '0;
      mdl_velocity     = '0;
      mdl_phase        = SEQ_SLOW0;
      mdl_pending      = 1'b0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed walk through the whole start sequence on one-edge windows
      write_csr(emsd_pkg::CSR_WINDOW_TICKS, 16'd1);
      write_csr(emsd_pkg::CSR_LOW_THRESHOLD, 16'sd1);
      write_csr(emsd_pkg::CSR_HIGH_THRESHOLD, 16'sd0);
      for (row = 0; row < DIRECTED_ROWS; row++) begin
         typed.position = directed_rows[row].position;
         typed.velocity = directed_rows[row].velocity;
         typed.phase    = directed_rows[row].phase;
         typed.pending  = directed_rows[row].pending;
         typed.done     = directed_rows[row].done;
         send_request(directed_rows[row].op, directed_rows[row].p2,
                      directed_rows[row].fixed, typed);
      end

      // Random windows under several settings; the first one finishes the
      // start left armed at the end of the directed walk
      run_phase(16'd2, 16'sd3, 16'sd8, 9, 220);
      run_phase(16'd1, -16'sd4, 16'sd2, 9, 140);
      // thresholds at the extremes: nothing is slow, nothing rises
      run_phase(16'd3, emsd_pkg::WIN_MIN, emsd_pkg::WIN_MAX, 9, 90);
      // and the reverse: everything is slow, nothing dips
      run_phase(16'd1, emsd_pkg::WIN_MAX, emsd_pkg::WIN_MIN, 9, 90);
      run_phase(16'd4, emsd_pkg::LOW_THRESHOLD_RST, emsd_pkg::HIGH_THRESHOLD_RST, 9, 140);
      // long stretch with no idling on either side
      run_phase(16'd2, 16'sd5, 16'sd12, 0, 140);

      // Wait out every response, then allow for stray late ones
      drain();
      repeat (8) @(posedge clock);
      if (mismatches == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule
